@@ src/sbpa_pkg.sv @@
// Shared constants, codes and control structs of the size-class pool allocator.
// Used by every module and interface of the block but sbpa_ram; depends on nothing.
package sbpa_pkg;

   localparam int MAX_CLASSES  = 8;
   localparam int CLS_W        = $clog2(MAX_CLASSES);
   localparam int CLS_FIELD_W  = 4;
   localparam int MAX_BLOCKS   = 1024;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int GUARD_BYTES  = 4;
   localparam int STACK_DEPTH  = MAX_CLASSES * MAX_BLOCKS;

   localparam int BASE_W       = 17;
   localparam int LEVEL_W      = 21;
   localparam int MAXLV_W      = 4;
   localparam int HDR_W        = 8;
   localparam int OP_W         = 2;
   localparam int SIZE_W       = 24;
   localparam int OFF_W        = 32;
   localparam int STAT_W       = 3;
   localparam int CTR_W        = 32;
   localparam int SHIFT_W      = BASE_W + CLS_W + 4;     // base << class
   localparam int STRIDE_W     = SHIFT_W + 1;
   localparam int POOL_W       = LEVEL_W + CLS_FIELD_W;
   localparam int PROD_A_W     = CLS_W + LEVEL_W;
   localparam int PROD_B_W     = IDX_W + STRIDE_W;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 21;
   localparam int DIV_W        = 32;
   localparam int DVS_W        = STRIDE_W;

   localparam logic [CLS_FIELD_W-1:0] NO_CLASS = CLS_FIELD_W'(MAX_CLASSES);

   localparam logic [BASE_W-1:0]  RST_BASE  = BASE_W'(16);
   localparam logic [LEVEL_W-1:0] RST_LEVEL = LEVEL_W'(16384);
   localparam logic [MAXLV_W-1:0] RST_MAXLV = MAXLV_W'(8);
   localparam logic [HDR_W-1:0]   RST_HDR   = HDR_W'(16);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE  = 2'd0,
      CSR_LEVEL = 2'd1,
      CSR_MAXLV = 2'd2,
      CSR_HDR   = 2'd3
   } csr_idx_type;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_FALLBACK = 3'd1,
      ST_REFUSED  = 3'd2,
      ST_EXTERN   = 3'd3,
      ST_BADFREE  = 3'd4,
      ST_CLEARED  = 3'd5
   } stat_type;

   typedef enum logic [1:0] {
      DIV_BUILD = 2'd0,
      DIV_OFF   = 2'd1,
      DIV_REL   = 2'd2
   } div_sel_type;

   // controller -> datapath
   typedef struct packed {
      logic        build_init;
      logic        build_store;
      logic        refill;
      logic        latch_req;
      logic        search;
      logic        pop_read;
      logic        pop_update;
      logic        mul;
      logic        sum;
      logic        free_split;
      logic        free_prep;
      logic        free_index;
      logic        push;
      logic        load_rsp;
      logic        div_start;
      div_sel_type div_sel;
      stat_type    res_code;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   req_zero;
      logic   in_pool;
      logic   alloc_ok;
      logic   rel_ok;
      logic   aligned;
      logic   can_push;
      logic   div_done;
      logic   build_last;
      logic   out_free;
   } dp_stat_type;

endpackage

@@ src/sbpa_channels.sv @@
// Request and response channel interfaces of the pool allocator.
// Depends on sbpa_pkg for field widths.
interface sbpa_req_if import sbpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [SIZE_W-1:0] req_size;
   logic [OFF_W-1:0]  mem_offset;

   modport source (output valid, output opcode, output req_size, output mem_offset,
                   input ready);
   modport sink   (input valid, input opcode, input req_size, input mem_offset,
                   output ready);
endinterface

interface sbpa_rsp_if import sbpa_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STAT_W-1:0]      status;
   logic [OFF_W-1:0]       payload_offset;
   logic [CLS_FIELD_W-1:0] size_class;
   logic [CNT_W-1:0]       class_in_use;
   logic [CLS_FIELD_W-1:0] active_classes;
   logic [CTR_W-1:0]       pool_allocs;
   logic [CTR_W-1:0]       pool_frees;
   logic [CTR_W-1:0]       system_allocs;
   logic [CTR_W-1:0]       system_frees;

   modport source (output valid, output status, output payload_offset, output size_class,
                   output class_in_use, output active_classes, output pool_allocs,
                   output pool_frees, output system_allocs, output system_frees,
                   input ready);
   modport sink   (input valid, input status, input payload_offset, input size_class,
                   input class_in_use, input active_classes, input pool_allocs,
                   input pool_frees, input system_allocs, input system_frees,
                   output ready);
endinterface

@@ src/sbpa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sbpa_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on sbpa_pkg.
module sbpa_div import sbpa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder
);

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff;
   logic [DVS_W:0]    rem_sh;
   logic [DVS_W:0]    diff;
   logic              ge;
   logic              busy;

   // one shift-subtract step
   always_comb begin
      busy   = (step_ff != '0);
      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
      diff   = rem_sh - {1'b0, dvs_ff};
      ge     = (rem_sh >= {1'b0, dvs_ff});
      quo_in = quo_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = STEP_W'(DIV_W);
      end else if (busy) begin
         quo_in  = {quo_ff[DIV_W-2:0], ge};
         rem_in  = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         step_in = step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= busy && (step_ff == STEP_W'(1)) && !start;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ src/sbpa_ctrl.sv @@
// Controller state machine of the pool allocator: sequences rebuild, allocate,
// free and clear through the datapath. Depends on sbpa_pkg.
module sbpa_ctrl import sbpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [17:0] {
      S_BINIT   = 18'b000000000000000001,
      S_BDIV    = 18'b000000000000000010,
      S_BWAIT   = 18'b000000000000000100,
      S_BFILL   = 18'b000000000000001000,
      S_IDLE    = 18'b000000000000010000,
      S_DECODE  = 18'b000000000000100000,
      S_SEARCH  = 18'b000000000001000000,
      S_ACHK    = 18'b000000000010000000,
      S_POPUPD  = 18'b000000000100000000,
      S_MUL     = 18'b000000001000000000,
      S_SUM     = 18'b000000010000000000,
      S_FDIV1   = 18'b000000100000000000,
      S_FCHK    = 18'b000001000000000000,
      S_FDSTART = 18'b000010000000000000,
      S_FDIV2   = 18'b000100000000000000,
      S_BRD     = 18'b001000000000000000,
      S_PUSH    = 18'b010000000000000000,
      S_RESULT  = 18'b100000000000000000
   } state_type;

   state_type state_ff, state_in;
   stat_type  res_ff, res_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      res_in    = res_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.div_sel = DIV_BUILD;
      unique case (state_ff)
         S_BINIT: begin
            cmd.build_init = 1'b1;
            state_in = S_BDIV;
         end
         S_BDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_BUILD;
            state_in = S_BWAIT;
         end
         S_BWAIT: begin
            if (stat.div_done) begin
               cmd.build_store = 1'b1;
               state_in = stat.build_last ? S_BFILL : S_BDIV;
            end
         end
         S_BFILL: begin
            cmd.refill = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.op)
               OP_ALLOC: begin
                  if (stat.req_zero) begin
                     res_in   = ST_REFUSED;
                     state_in = S_RESULT;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end
               OP_FREE: begin
                  if (stat.in_pool) begin
                     cmd.div_start = 1'b1;
                     cmd.div_sel   = DIV_OFF;
                     state_in = S_FDIV1;
                  end else begin
                     res_in   = ST_EXTERN;
                     state_in = S_RESULT;
                  end
               end
               OP_CLEAR: begin
                  cmd.refill = 1'b1;
                  res_in   = ST_CLEARED;
                  state_in = S_RESULT;
               end
               default: begin
                  res_in   = ST_REFUSED;
                  state_in = S_RESULT;
               end
            endcase
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            state_in = S_ACHK;
         end
         S_ACHK: begin
            if (stat.alloc_ok) begin
               cmd.pop_read = 1'b1;
               state_in = S_POPUPD;
            end else begin
               res_in   = ST_FALLBACK;
               state_in = S_RESULT;
            end
         end
         S_POPUPD: begin
            cmd.pop_update = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum = 1'b1;
            res_in   = ST_OK;
            state_in = S_RESULT;
         end
         S_FDIV1: begin
            if (stat.div_done) begin
               cmd.free_split = 1'b1;
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            cmd.free_prep = 1'b1;
            if (stat.rel_ok) begin
               state_in = S_FDSTART;
            end else begin
               res_in   = ST_BADFREE;
               state_in = S_RESULT;
            end
         end
         S_FDSTART: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_REL;
            state_in = S_FDIV2;
         end
         S_FDIV2: begin
            if (stat.div_done) begin
               cmd.free_index = 1'b1;
               if (stat.aligned) begin
                  state_in = S_BRD;
               end else begin
                  res_in   = ST_BADFREE;
                  state_in = S_RESULT;
               end
            end
         end
         // busy bit read is in flight
         S_BRD: begin
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (stat.can_push) begin
               cmd.push = 1'b1;
               res_in   = ST_OK;
            end else begin
               res_in   = ST_BADFREE;
            end
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_BINIT;
         end
      endcase
      cmd.res_code = res_ff;
      // any register write rebuilds the pool
      if (csr_wr_en) begin
         state_in = S_BINIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BINIT;
         res_ff   <= ST_REFUSED;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

endmodule

@@ src/sbpa_dp.sv @@
// Datapath of the pool allocator: configuration, class table, free stacks,
// busy bits, divider, address arithmetic and the result register.
// Depends on sbpa_pkg, sbpa_ram and sbpa_div.
module sbpa_dp import sbpa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  dp_cmd_type              cmd,
   output dp_stat_type             stat,
   input  logic [OP_W-1:0]         req_opcode,
   input  logic [SIZE_W-1:0]       req_size,
   input  logic [OFF_W-1:0]        req_mem_offset,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [STAT_W-1:0]       rsp_status,
   output logic [OFF_W-1:0]        rsp_payload_offset,
   output logic [CLS_FIELD_W-1:0]  rsp_size_class,
   output logic [CNT_W-1:0]        rsp_class_in_use,
   output logic [CLS_FIELD_W-1:0]  rsp_active_classes,
   output logic [CTR_W-1:0]        rsp_pool_allocs,
   output logic [CTR_W-1:0]        rsp_pool_frees,
   output logic [CTR_W-1:0]        rsp_system_allocs,
   output logic [CTR_W-1:0]        rsp_system_frees
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);

   function automatic logic [STRIDE_W-1:0] stride_of(input logic [BASE_W-1:0] b,
                                                     input logic [HDR_W-1:0]  h,
                                                     input logic [CLS_W-1:0]  c);
      logic [SHIFT_W-1:0] sh;
      sh = SHIFT_W'(b) << c;
      return STRIDE_W'(sh) + STRIDE_W'(h) + STRIDE_W'(GUARD_BYTES);
   endfunction

   // configuration
   logic [BASE_W-1:0]  base_ff;
   logic [LEVEL_W-1:0] lb_ff;
   logic [MAXLV_W-1:0] maxlv_ff;
   logic [HDR_W-1:0]   hdr_ff;

   // class table
   logic [CLS_FIELD_W-1:0] total_ff, total_in;
   logic [POOL_W-1:0]      pool_ff;
   logic [CLS_W-1:0]       k_ff;
   logic [CNT_W-1:0]       count_ff [MAX_CLASSES];
   logic [CNT_W-1:0]       fill_ff  [MAX_CLASSES];
   logic [CNT_W-1:0]       lw_ff    [MAX_CLASSES];

   // operation registers
   op_type                 op_ff;
   logic [SIZE_W-1:0]      size_ff;
   logic [OFF_W-1:0]       off_ff;
   logic [CLS_FIELD_W-1:0] cls_ff, cls_in;
   logic [STRIDE_W-1:0]    stride_ff;
   logic [LEVEL_W-1:0]     rel_ff;
   logic [LEVEL_W-1:0]     r_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [PROD_A_W-1:0]    prod_a_ff;
   logic [PROD_B_W-1:0]    prod_b_ff;
   logic [OFF_W-1:0]       pay_ff;

   // counters and result register
   logic [CTR_W-1:0]       pa_ff, pf_ff, sa_ff, sf_ff;
   logic [CTR_W-1:0]       pa_in, pf_in, sa_in, sf_in;
   logic                   rsp_valid_ff;
   stat_type               rsp_status_ff;
   logic [OFF_W-1:0]       rsp_pay_ff;
   logic [CLS_FIELD_W-1:0] rsp_cls_ff;
   logic [CNT_W-1:0]       rsp_use_ff;
   logic [CLS_FIELD_W-1:0] rsp_total_ff;

   // helpers
   logic [CLS_W-1:0]       csel;
   logic [CNT_W-1:0]       count_sel, fill_sel, lw_sel, pop_pos, in_use;
   logic [IDX_W-1:0]       pop_val;
   logic [MAX_CLASSES-1:0] lvl_ok, hit;
   logic [DIV_W-1:0]       div_dividend, div_quo;
   logic [DVS_W-1:0]       div_divisor, div_rem;
   logic                   div_done;
   logic [IDX_W-1:0]       stk_rd_data;
   logic                   busy_rd_data;
   logic                   busy_we, busy_wdata;
   logic [ADDR_W-1:0]      busy_waddr;
   logic [CNT_W-1:0]       build_cnt;
   logic [PROD_B_W-1:0]    pay_sum;

   assign csel      = cls_ff[CLS_W-1:0];
   assign count_sel = count_ff[csel];
   assign fill_sel  = fill_ff[csel];
   assign lw_sel    = lw_ff[csel];
   assign pop_pos   = fill_sel - 1'b1;

   // number of classes: leading run of classes, under the max-level setting, whose stride fits a level
   always_comb begin
      total_in = CLS_FIELD_W'(MAX_CLASSES);
      for (int c = 0; c < MAX_CLASSES; c++) begin
         lvl_ok[c] = (maxlv_ff > MAXLV_W'(c)) &&
                     (stride_of(base_ff, hdr_ff, CLS_W'(c)) < STRIDE_W'(lb_ff));
      end
      for (int c = MAX_CLASSES - 1; c >= 0; c--) begin
         if (!lvl_ok[c]) begin
            total_in = CLS_FIELD_W'(c);
         end
      end
   end

   // first class whose payload fits the request
   always_comb begin
      cls_in = NO_CLASS;
      for (int c = 0; c < MAX_CLASSES; c++) begin
         hit[c] = (total_ff > CLS_FIELD_W'(c)) &&
                  ((SHIFT_W'(base_ff) << c) >= SHIFT_W'(size_ff));
      end
      for (int c = MAX_CLASSES - 1; c >= 0; c--) begin
         if (hit[c]) begin
            cls_in = CLS_FIELD_W'(c);
         end
      end
   end

   // block count of the class being built, saturated; zero for an inactive class
   assign build_cnt = (k_ff >= CLS_W'(total_ff)) && (total_ff != CLS_FIELD_W'(MAX_CLASSES))
                      ? '0
                      : ((div_quo > DIV_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                        : div_quo[CNT_W-1:0]);

   // popped index: untouched stack slots hold their refill value
   assign pop_val = (pop_pos < lw_sel) ? IDX_W'(count_sel - fill_sel) : stk_rd_data;

   assign in_use  = (cls_ff != NO_CLASS) ? (count_sel - fill_sel) : '0;
   assign pay_sum = PROD_B_W'(prod_a_ff) + prod_b_ff + PROD_B_W'(hdr_ff);

   // divider operand selection
   always_comb begin
      unique case (cmd.div_sel)
         DIV_BUILD: begin
            div_dividend = DIV_W'(lb_ff);
            div_divisor  = stride_of(base_ff, hdr_ff, k_ff);
         end
         DIV_OFF: begin
            div_dividend = off_ff;
            div_divisor  = DVS_W'(lb_ff);
         end
         DIV_REL: begin
            div_dividend = DIV_W'(r_ff);
            div_divisor  = stride_ff;
         end
         default: begin
            div_dividend = DIV_W'(lb_ff);
            div_divisor  = stride_ff;
         end
      endcase
   end

   sbpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // free stacks, one region of MAX_BLOCKS entries per class
   sbpa_ram #(.WIDTH(IDX_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr ({csel, fill_sel[IDX_W-1:0]}),
      .wr_data (idx_ff),
      .rd_addr ({csel, pop_pos[IDX_W-1:0]}),
      .rd_data (stk_rd_data)
   );

   // busy bits; valid only for indices already handed out since the last refill
   assign busy_we    = cmd.pop_update || cmd.push;
   assign busy_wdata = cmd.pop_update;
   assign busy_waddr = cmd.pop_update ? {csel, pop_val} : {csel, idx_ff};

   sbpa_ram #(.WIDTH(1), .DEPTH(STACK_DEPTH)) u_busy (
      .clock   (clock),
      .wr_en   (busy_we),
      .wr_addr (busy_waddr),
      .wr_data (busy_wdata),
      .rd_addr ({csel, idx_ff}),
      .rd_data (busy_rd_data)
   );

   // status to controller
   always_comb begin
      stat.op         = op_ff;
      stat.req_zero   = (size_ff == '0);
      stat.in_pool    = (off_ff < OFF_W'(pool_ff));
      stat.alloc_ok   = (cls_ff != NO_CLASS) && (fill_sel != '0);
      stat.rel_ok     = (count_sel != '0) && (rel_ff >= LEVEL_W'(hdr_ff));
      stat.aligned    = (div_rem == '0) && (div_quo < DIV_W'(count_sel));
      stat.can_push   = busy_rd_data && (CNT_W'(idx_ff) < (count_sel - lw_sel)) &&
                        (fill_sel < CNT_W'(MAX_BLOCKS));
      stat.div_done   = div_done;
      stat.build_last = (k_ff == CLS_W'(MAX_CLASSES - 1));
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // counter updates on result load
   always_comb begin
      pa_in = pa_ff;
      pf_in = pf_ff;
      sa_in = sa_ff;
      sf_in = sf_ff;
      if (cmd.load_rsp) begin
         if (op_ff == OP_ALLOC && cmd.res_code == ST_OK) begin
            pa_in = pa_ff + 1'b1;
         end
         if (cmd.res_code == ST_FALLBACK) begin
            sa_in = sa_ff + 1'b1;
         end
         if (op_ff == OP_FREE && (cmd.res_code == ST_OK || cmd.res_code == ST_BADFREE)) begin
            pf_in = pf_ff + 1'b1;
         end
         if (cmd.res_code == ST_EXTERN) begin
            sf_in = sf_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= RST_BASE;
         lb_ff        <= RST_LEVEL;
         maxlv_ff     <= RST_MAXLV;
         hdr_ff       <= RST_HDR;
         pa_ff        <= '0;
         pf_ff        <= '0;
         sa_ff        <= '0;
         sf_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_idx_type'(csr_index))
               CSR_BASE:  base_ff  <= csr_wdata[BASE_W-1:0];
               CSR_LEVEL: lb_ff    <= csr_wdata[LEVEL_W-1:0];
               CSR_MAXLV: maxlv_ff <= csr_wdata[MAXLV_W-1:0];
               CSR_HDR:   hdr_ff   <= csr_wdata[HDR_W-1:0];
               default:   base_ff  <= base_ff;
            endcase
         end
         pa_ff <= pa_in;
         pf_ff <= pf_in;
         sa_ff <= sa_in;
         sf_ff <= sf_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // class table and stacks bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.build_init) begin
         total_ff <= total_in;
         k_ff     <= '0;
      end
      if (cmd.div_start && cmd.div_sel == DIV_BUILD) begin
         pool_ff <= POOL_W'(lb_ff) * POOL_W'(total_ff);
      end
      if (cmd.build_store) begin
         count_ff[k_ff] <= build_cnt;
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.refill) begin
         for (int c = 0; c < MAX_CLASSES; c++) begin
            fill_ff[c] <= count_ff[c];
            lw_ff[c]   <= count_ff[c];
         end
      end
      if (cmd.pop_update) begin
         fill_ff[csel] <= pop_pos;
         if (pop_pos < lw_sel) begin
            lw_ff[csel] <= pop_pos;
         end
      end
      if (cmd.push) begin
         fill_ff[csel] <= fill_sel + 1'b1;
      end
   end

   // per-operation payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff   <= op_type'(req_opcode);
         size_ff <= req_size;
         off_ff  <= req_mem_offset;
         cls_ff  <= NO_CLASS;
         pay_ff  <= '0;
      end
      if (cmd.search) begin
         cls_ff <= cls_in;
      end
      if (cmd.pop_read) begin
         stride_ff <= stride_of(base_ff, hdr_ff, csel);
      end
      if (cmd.pop_update) begin
         idx_ff <= pop_val;
      end
      if (cmd.mul) begin
         prod_a_ff <= PROD_A_W'(csel) * PROD_A_W'(lb_ff);
         prod_b_ff <= PROD_B_W'(idx_ff) * PROD_B_W'(stride_ff);
      end
      if (cmd.sum) begin
         pay_ff <= pay_sum[OFF_W-1:0];
      end
      if (cmd.free_split) begin
         cls_ff <= CLS_FIELD_W'(div_quo[CLS_W-1:0]);
         rel_ff <= div_rem[LEVEL_W-1:0];
      end
      if (cmd.free_prep) begin
         stride_ff <= stride_of(base_ff, hdr_ff, csel);
         r_ff      <= rel_ff - LEVEL_W'(hdr_ff);
      end
      if (cmd.free_index) begin
         idx_ff <= div_quo[IDX_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.res_code;
         rsp_pay_ff    <= pay_ff;
         rsp_cls_ff    <= cls_ff;
         rsp_use_ff    <= in_use;
         rsp_total_ff  <= total_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_pay_ff;
   assign rsp_size_class     = rsp_cls_ff;
   assign rsp_class_in_use   = rsp_use_ff;
   assign rsp_active_classes = rsp_total_ff;
   assign rsp_pool_allocs    = pa_ff;
   assign rsp_pool_frees     = pf_ff;
   assign rsp_system_allocs  = sa_ff;
   assign rsp_system_frees   = sf_ff;

endmodule

@@ src/size_class_block_pool_allocator_unit.sv @@
// Size-class block pool allocator, top level. One item at a time.
// A good free runs two serial divisions in the shared divider; request ready returns in
// the cycle that the result turns valid.
// Reset and every register write rebuild the class table (8 divisions)
// with req ready low; stacks refill by per-class fill marks.
module size_class_block_pool_allocator_unit import sbpa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   sbpa_req_if.sink              req_chan,
   sbpa_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   sbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sbpa_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .stat               (stat),
      .req_opcode         (req_chan.opcode),
      .req_size           (req_chan.req_size),
      .req_mem_offset     (req_chan.mem_offset),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_status         (rsp_chan.status),
      .rsp_payload_offset (rsp_chan.payload_offset),
      .rsp_size_class     (rsp_chan.size_class),
      .rsp_class_in_use   (rsp_chan.class_in_use),
      .rsp_active_classes (rsp_chan.active_classes),
      .rsp_pool_allocs    (rsp_chan.pool_allocs),
      .rsp_pool_frees     (rsp_chan.pool_frees),
      .rsp_system_allocs  (rsp_chan.system_allocs),
      .rsp_system_frees   (rsp_chan.system_frees)
   );

endmodule

@@ src/sbpa_chk.sv @@
// Port-level checker for the pool allocator and its bind to the top level.
// Depends on sbpa_pkg.
module sbpa_chk import sbpa_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STAT_W-1:0]      rsp_status,
   input logic [OFF_W-1:0]       rsp_payload_offset,
   input logic [CLS_FIELD_W-1:0] rsp_size_class,
   input logic [CNT_W-1:0]       rsp_class_in_use
);

   // items accepted whose result has not been transferred yet
   logic [1:0] pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped before transfer");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without an accepted request");

   a_no_class_use: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_size_class == NO_CLASS |-> rsp_class_in_use == '0)
      else $error("in-use count reported without a class");

   a_clear_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_CLEARED |->
         rsp_size_class == NO_CLASS && rsp_payload_offset == '0)
      else $error("clear result carries a class or offset");

endmodule

bind size_class_block_pool_allocator_unit sbpa_chk u_sbpa_chk (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_status         (rsp_chan.status),
   .rsp_payload_offset (rsp_chan.payload_offset),
   .rsp_size_class     (rsp_chan.size_class),
   .rsp_class_in_use   (rsp_chan.class_in_use)
);
